// ----- design/stg_pkg.sv -----
// Shared constants, types and sine table builder for the sine tone generator.
`timescale 1ns / 1ps

package stg_pkg;

  localparam int PHASE_WIDTH     = 32;
  localparam int TABLE_ADDR_BITS = 12;
  localparam int INC_W           = 32;
  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = SAMPLE_W - 1;
  localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
  localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
  localparam int SERIES_TERMS    = 12;

  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

  localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // (2n)(2n+1) divisors of the Taylor series, innermost term last
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t rom_t [QUARTER_LEN];

  // Table lookup request handed from the phase stage to the table stage.
  typedef struct packed {
    logic [QUARTER_BITS-1:0] addr;  // quarter-wave index
    logic                    neg;   // lower half cycle
    logic                    peak;  // exact quarter point
  } lookup_t;

  // Q2.62 product, truncated.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Truncated full-scale sine of pi*m/2^(TABLE_ADDR_BITS-1), elaboration only.
  function automatic mag_t sine_mag(int m);
    logic [127:0] p;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  t;
    logic [63:0]  res;
    int           i;
    p  = {64'd0, PI_Q62} * 128'(m);
    x  = p[TABLE_ADDR_BITS-1 +: 64];
    x2 = mul_q62(x, x);
    t  = Q62_ONE;
    for (i = SERIES_TERMS - 1; i >= 0; i--) begin
      t = Q62_ONE - (mul_q62(x2, t) / SERIES_DIV[i]);
    end
    res = mul_q62(x, t) >> 47;
    return res[MAG_W-1:0];
  endfunction

  // Quarter-wave magnitude table, entry 0 is the zero crossing.
  function automatic rom_t build_sine_rom();
    rom_t r;
    int   i;
    r[0] = '0;
    for (i = 1; i < QUARTER_LEN; i++) begin
      r[i] = sine_mag(i);
    end
    return r;
  endfunction

endpackage

// ----- design/stg_phase_acc.sv -----
// Phase accumulator, increment register and quarter-wave address folding.
`timescale 1ns / 1ps

module stg_phase_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stg_pkg::INC_W-1:0]      cfg_wdata,
  input  logic                           accept,
  input  logic                           restart,
  output stg_pkg::lookup_t               lookup
);

  logic [stg_pkg::INC_W-1:0]                       phase_inc_r;
  logic [stg_pkg::PHASE_WIDTH-1:0]                 phase_acc_r;
  logic [stg_pkg::PHASE_WIDTH-1:0]                 phase_acc_nxt;
  logic [stg_pkg::PHASE_WIDTH-1:0]                 phase_cur;
  logic [stg_pkg::PHASE_WIDTH+stg_pkg::INC_W-1:0]  phase_sum;
  logic [stg_pkg::TABLE_ADDR_BITS-1:0]             k;
  logic [1:0]                                      quadrant;
  logic [stg_pkg::QUARTER_BITS-1:0]                r;

  // restart clears phase before this sample is taken
  assign phase_cur = restart ? '0 : phase_acc_r;
  assign phase_sum = {{stg_pkg::INC_W{1'b0}}, phase_cur}
                   + {{stg_pkg::PHASE_WIDTH{1'b0}}, phase_inc_r};

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    if (accept) begin
      phase_acc_nxt = phase_sum[stg_pkg::PHASE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      phase_acc_r <= '0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      if (cfg_we) begin
        phase_inc_r <= cfg_wdata;
      end
    end
  end

  assign k        = phase_cur[stg_pkg::PHASE_WIDTH-1 -: stg_pkg::TABLE_ADDR_BITS];
  assign quadrant = k[stg_pkg::TABLE_ADDR_BITS-1 -: 2];
  assign r        = k[stg_pkg::QUARTER_BITS-1:0];

  // odd quadrants run the table backwards; r == 0 there is the peak
  always_comb begin
    lookup.neg = quadrant[1];
    if (quadrant[0]) begin
      lookup.addr = '0 - r;
      lookup.peak = (r == '0);
    end else begin
      lookup.addr = r;
      lookup.peak = 1'b0;
    end
  end

endmodule

// ----- design/stg_sine_rom.sv -----
// Quarter-wave sine magnitude ROM with registered read.
`timescale 1ns / 1ps

module stg_sine_rom (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [stg_pkg::QUARTER_BITS-1:0] rd_addr,
  output stg_pkg::mag_t                    rd_data
);

  localparam stg_pkg::rom_t ROM_DATA = stg_pkg::build_sine_rom();

  stg_pkg::mag_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_DATA[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/sine_tone_generator_unit.sv -----
// Top level of the direct digital synthesis sine tone generator.
`timescale 1ns / 1ps

// Usage:
//   Each transaction on the in_ channel requests one sample; in_restart set
//   clears the phase to zero first, so that sample is 0 (start of a buffer).
//   Every request gives exactly one transaction on the out_ channel carrying
//   out_sample, a signed 16-bit PCM value, saturated to +32767 at the peak.
//   cfg_we/cfg_wdata load the 32-bit phase increment, freq/fs * 2^32; write
//   it only while no request is in flight.
// Pipeline:
//   before the accepting edge: phase select, address fold, ROM address
//   accepting edge: phase advance, quarter-wave ROM register (1024 x 15 bits)
//   next advancing edge: sign and saturation into the output register
//   A request passes the table stage register, then the output register, before
//   out_valid rises. One sample per cycle sustained while out_stall is low; the
//   ROM read port and the phase adder each take one transaction a cycle.
// Stall:
//   out_stall freezes the whole pipeline; in_stall equals out_stall while the
//   output register holds a result and is low whenever that register is empty.
// Reset (rst_n, synchronous): phase and increment clear to 0, pipeline empties.
module sine_tone_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [stg_pkg::INC_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [stg_pkg::SAMPLE_W-1:0] out_sample
);

  logic                           advance;
  logic                           accept;
  stg_pkg::lookup_t               lookup;
  stg_pkg::mag_t                  rom_q;

  // table stage
  logic                           a_valid_r;
  logic                           a_neg_r;
  logic                           a_peak_r;

  // output stage
  logic                           out_valid_r;
  logic [stg_pkg::SAMPLE_W-1:0]   out_sample_r;
  logic [stg_pkg::SAMPLE_W-1:0]   mag_ext;
  logic [stg_pkg::SAMPLE_W-1:0]   sample_nxt;

  // pipeline moves whenever the output slot is empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign accept   = in_valid && advance;
  assign in_stall = !advance;

  stg_phase_acc u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .restart   (in_restart),
    .lookup    (lookup)
  );

  stg_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (lookup.addr),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_neg_r  <= lookup.neg;
      a_peak_r <= lookup.peak;
    end
  end

  // peak reads as full scale; sign applied after truncation
  always_comb begin
    mag_ext = a_peak_r ? stg_pkg::SAMPLE_NEG_MAX : {1'b0, rom_q};
    if (a_neg_r) begin
      sample_nxt = '0 - mag_ext;
    end else if (a_peak_r) begin
      sample_nxt = stg_pkg::SAMPLE_POS_MAX;
    end else begin
      sample_nxt = mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

`ifndef SYNTH
  // a restart transaction always looks up the zero crossing
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_restart |=> a_valid_r && !a_peak_r && !a_neg_r)
    else $error("restart did not select the zero crossing");

  // table stage holds its transaction while the output is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !advance |=> a_valid_r && $stable(a_neg_r) && $stable(a_peak_r))
    else $error("table stage lost a transaction under stall");

  // positive peak saturates
  a_pos_peak: assert property (@(posedge clk) disable iff (!rst_n)
    advance && a_valid_r && a_peak_r && !a_neg_r |=>
      out_valid_r && out_sample_r == stg_pkg::SAMPLE_POS_MAX)
    else $error("positive peak not saturated");

  // output slot only fills from a valid table stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !a_valid_r |=> !out_valid_r)
    else $error("result produced without a transaction");
`endif

endmodule
